/* rtl/tcrs_pkg.sv */
// Shared types, constants and color tables for the terrain color ramp shader.
`timescale 1ns / 1ps

package tcrs_pkg;

   typedef logic [16:0] tcrs_color_type;

   typedef enum logic [2:0] {
      KIND_WATER,
      KIND_WHITE,
      KIND_SEG1,
      KIND_SEG2,
      KIND_SEG3,
      KIND_SEG4
   } tcrs_kind_type;

   typedef struct packed {
      tcrs_color_type [2:0] base;
      logic [2:0][17:0]     diff;
      logic [15:0]          weight;
      logic [31:0]          sun;
   } tcrs_work_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [19:0] TH_SEG1 = 20'd24576;
   localparam logic [19:0] TH_SEG2 = 20'd53248;
   localparam logic [19:0] TH_SEG3 = 20'd57344;
   localparam logic [19:0] TH_SEG4 = 20'd73728;

   localparam logic signed [15:0] SUN_X = 16'sd14301;
   localparam logic signed [15:0] SUN_Y = 16'sd7151;
   localparam logic signed [15:0] SUN_Z = 16'sd3575;

   localparam logic [17:0] RECIP6 = 18'd174762;
   localparam logic [17:0] RECIP7 = 18'd149796;

   localparam tcrs_color_type RAMP_COL [5][3] = '{
      '{17'd9830,  17'd19661, 17'd9830},
      '{17'd19661, 17'd29491, 17'd19661},
      '{17'd32768, 17'd32768, 17'd22938},
      '{17'd26214, 17'd23593, 17'd21627},
      '{17'd72090, 17'd72090, 17'd72090}
   };

   localparam tcrs_color_type WATER_COL [3] = '{17'd16384, 17'd26870, 17'd57672};

   localparam logic [7:0] ALPHA = 8'hFF;

endpackage

/* rtl/tcrs_front.sv */
// Front pipeline: classify height, form blend weight, sunlight and ramp colors.
`timescale 1ns / 1ps

module tcrs_front import tcrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [15:0]   height,
   input  logic [15:0]   normal_x,
   input  logic [15:0]   normal_y,
   input  logic [15:0]   normal_z,
   output logic          out_valid,
   input  logic          out_ready,
   output tcrs_work_type out_work
);

   logic advance;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   tcrs_kind_type        s1_kind_ff, s2_kind_ff;
   logic [18:0]          s1_num_ff, s2_num_ff;
   logic [12:0]          s1_wf_ff;
   logic signed [31:0]   s1_px_ff, s1_py_ff, s1_pz_ff;
   logic [16:0]          s2_quot_ff;
   logic [31:0]          s2_sun_ff;
   tcrs_work_type        s3_work_ff;

   tcrs_kind_type        s1_kind_in;
   logic [18:0]          s1_num_in;
   logic [12:0]          s1_wf_in;
   logic signed [31:0]   s1_px_in, s1_py_in, s1_pz_in;
   logic [16:0]          s2_quot_in;
   logic [31:0]          s2_sun_in;
   tcrs_work_type        s3_work_in;

   logic [19:0]          h20, base, hdiff;
   logic signed [19:0]   hs, d_raw;
   logic [11:0]          d_clip;
   logic [36:0]          recip_prod;
   logic signed [33:0]   dot, sun_full;
   logic [2:0]           divisor;
   logic [19:0]          qd, rem;
   logic [16:0]          quot;

   assign advance   = !s3_valid_ff || out_ready;
   assign in_ready  = advance;
   assign out_valid = s3_valid_ff;
   assign out_work  = s3_work_ff;

   always_comb begin
      h20   = {1'b0, height[14:0], 4'b0} + {3'b0, height[14:0], 2'b0};
      hs    = {{4{height[15]}}, height};
      d_raw = 20'sd4096 + (hs <<< 2) + (hs <<< 1);
      d_clip   = d_raw[19] ? 12'd0 : d_raw[11:0];
      s1_wf_in = 13'd4096 + {1'b0, d_clip};
      base = 20'd0;
      if (height[15]) begin
         s1_kind_in = KIND_WATER;
      end else if (h20 < TH_SEG1) begin
         s1_kind_in = KIND_SEG1;
      end else if (h20 < TH_SEG2) begin
         s1_kind_in = KIND_SEG2;
         base = TH_SEG1;
      end else if (h20 < TH_SEG3) begin
         s1_kind_in = KIND_SEG3;
         base = TH_SEG2;
      end else if (h20 < TH_SEG4) begin
         s1_kind_in = KIND_SEG4;
         base = TH_SEG3;
      end else begin
         s1_kind_in = KIND_WHITE;
      end
      hdiff = h20 - base;
      if (s1_kind_in == KIND_WATER || s1_kind_in == KIND_WHITE) begin
         s1_num_in = 19'd0;
      end else begin
         s1_num_in = {hdiff[14:0], 4'b0};
      end
      s1_px_in = $signed(normal_x) * SUN_X;
      s1_py_in = $signed(normal_y) * SUN_Y;
      s1_pz_in = $signed(normal_z) * SUN_Z;
   end

   always_comb begin
      recip_prod = s1_num_ff * ((s1_kind_ff == KIND_SEG2) ? RECIP7 : RECIP6);
      unique case (s1_kind_ff)
         KIND_SEG1, KIND_SEG2: s2_quot_in = recip_prod[36:20];
         KIND_SEG3:            s2_quot_in = s1_num_ff[16:0];
         KIND_SEG4:            s2_quot_in = s1_num_ff[18:2];
         default:              s2_quot_in = 17'd0;
      endcase
      dot      = s1_px_ff + s1_py_ff + s1_pz_ff;
      sun_full = 34'sd268435456 - dot;
      if (s1_kind_ff == KIND_WATER) begin
         s2_sun_in = {4'b0, s1_wf_ff, 15'b0};
      end else begin
         s2_sun_in = sun_full[31:0];
      end
   end

   always_comb begin
      divisor = (s2_kind_ff == KIND_SEG2) ? 3'd7 : 3'd6;
      qd      = s2_quot_ff * divisor;
      rem     = {1'b0, s2_num_ff} - qd;
      quot    = s2_quot_ff;
      if ((s2_kind_ff == KIND_SEG1 || s2_kind_ff == KIND_SEG2) && rem >= {17'd0, divisor}) begin
         quot = s2_quot_ff + 17'd1;
      end
      s3_work_in.sun    = s2_sun_ff;
      s3_work_in.weight = quot[15:0];
      for (int c = 0; c < 3; c++) begin
         unique case (s2_kind_ff)
            KIND_WATER: begin
               s3_work_in.base[c] = WATER_COL[c];
               s3_work_in.diff[c] = 18'd0;
            end
            KIND_SEG1: begin
               s3_work_in.base[c] = RAMP_COL[0][c];
               s3_work_in.diff[c] = {1'b0, RAMP_COL[1][c]} - {1'b0, RAMP_COL[0][c]};
            end
            KIND_SEG2: begin
               s3_work_in.base[c] = RAMP_COL[1][c];
               s3_work_in.diff[c] = {1'b0, RAMP_COL[2][c]} - {1'b0, RAMP_COL[1][c]};
            end
            KIND_SEG3: begin
               s3_work_in.base[c] = RAMP_COL[2][c];
               s3_work_in.diff[c] = {1'b0, RAMP_COL[3][c]} - {1'b0, RAMP_COL[2][c]};
            end
            KIND_SEG4: begin
               s3_work_in.base[c] = RAMP_COL[3][c];
               s3_work_in.diff[c] = {1'b0, RAMP_COL[4][c]} - {1'b0, RAMP_COL[3][c]};
            end
            default: begin
               s3_work_in.base[c] = RAMP_COL[4][c];
               s3_work_in.diff[c] = 18'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff <= s1_kind_in;
         s1_num_ff  <= s1_num_in;
         s1_wf_ff   <= s1_wf_in;
         s1_px_ff   <= s1_px_in;
         s1_py_ff   <= s1_py_in;
         s1_pz_ff   <= s1_pz_in;
         s2_kind_ff <= s1_kind_ff;
         s2_num_ff  <= s1_num_ff;
         s2_quot_ff <= s2_quot_in;
         s2_sun_ff  <= s2_sun_in;
         s3_work_ff <= s3_work_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !out_ready) |=> (s3_valid_ff && $stable(s3_work_ff)))
      else $error("front stage 3 item changed while stalled");
`endif

endmodule

/* rtl/tcrs_queue.sv */
// Small FIFO decoupling the front pipeline from the back pipeline.
`timescale 1ns / 1ps

module tcrs_queue import tcrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_valid,
   output logic          wr_ready,
   input  tcrs_work_type wr_work,
   output logic          rd_valid,
   input  logic          rd_ready,
   output tcrs_work_type rd_work
);

   tcrs_work_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   wr_fire, rd_fire;

   assign wr_ready = (count_ff != QUEUE_DEPTH[QUEUE_PTR_W:0]);
   assign rd_valid = (count_ff != '0);
   assign rd_work  = entry_ff[rd_ptr_ff];
   assign wr_fire  = wr_valid && wr_ready;
   assign rd_fire  = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_fire && !rd_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_fire && rd_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         entry_ff[wr_ptr_ff] <= wr_work;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_DEPTH[QUEUE_PTR_W:0])
      else $error("queue count beyond depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (wr_fire && !rd_fire) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on write");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_DEPTH[QUEUE_PTR_W:0]) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

/* rtl/tcrs_back.sv */
// Back pipeline: blend ramp colors, apply sunlight, clamp and pack the pixel.
`timescale 1ns / 1ps

module tcrs_back import tcrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tcrs_work_type in_work,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [31:0]   pixel_abgr
);

   logic advance;

   logic                     b1_valid_ff, b2_valid_ff, out_valid_ff;
   tcrs_color_type [2:0]     b1_base_ff;
   logic signed [34:0]       b1_prod_ff [3];
   logic [31:0]              b1_sun_ff;
   logic signed [49:0]       b2_val_ff [3];
   logic [31:0]              pixel_ff;

   logic signed [34:0]       b1_prod_in [3];
   logic signed [49:0]       b2_val_in [3];
   logic [31:0]              pixel_in;
   logic signed [18:0]       col_s [3];

   function automatic logic [7:0] to_byte(input logic signed [49:0] v);
      logic [51:0] t;
      t = {v[43:0], 8'b0} - {8'b0, v[43:0]};
      if (v <= 50'sd0) begin
         return 8'd0;
      end else if (v >= 50'sd17592186044416) begin
         return 8'd255;
      end
      return t[51:44];
   endfunction

   assign advance    = !out_valid_ff || out_ready;
   assign in_ready   = advance;
   assign out_valid  = out_valid_ff;
   assign pixel_abgr = pixel_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         b1_prod_in[c] = $signed(in_work.diff[c]) * $signed({1'b0, in_work.weight});
         col_s[c]      = $signed({2'b0, b1_base_ff[c]}) + 19'(b1_prod_ff[c] >>> 16);
         b2_val_in[c]  = $signed({1'b0, col_s[c][16:0]}) * $signed(b1_sun_ff);
      end
      pixel_in = {ALPHA, to_byte(b2_val_ff[2]), to_byte(b2_val_ff[1]), to_byte(b2_val_ff[0])};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= in_valid;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_base_ff <= in_work.base;
         b1_sun_ff  <= in_work.sun;
         b1_prod_ff <= b1_prod_in;
         b2_val_ff  <= b2_val_in;
         pixel_ff   <= pixel_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_no_take: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> (out_valid_ff && $stable(b2_valid_ff)))
      else $error("back pipeline moved while output stalled");
`endif

endmodule

/* rtl/terrain_color_ramp_shader.sv */
// Top level of the terrain color ramp shader with hillshade.
`timescale 1ns / 1ps

// Usage:
//   req channel: one item per pixel, req_tdata carries height (Q3.12) and the
//   three normal components (Q1.14), all signed.
//   rsp channel: one item per req item, in order, rsp_tdata is the packed ABGR pixel.
//   Throughput: one item per clock while the rsp side does not stall, set by the fully pipelined front and back.
//   Path from req acceptance to rsp_tvalid: 3 front stages, one queue write,
//   then 3 back stages ending in the output register.
//   A 4-entry queue sits between front and back; when the rsp side stalls the
//   back holds, the queue fills, and then the front and req_tready stall.
//   Reset clears all valid flags and the queue; no items survive reset and no
//   clearing pass is needed.
//   Water is not sunlit but scaled by a height-based factor; land is scaled by sunlight and each channel clamps.
//   Alpha is always 255.
module terrain_color_ramp_shader import tcrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // height, normal_x, normal_y, normal_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // pixel_abgr
);

   logic          front_valid, front_ready, back_valid, back_ready;
   tcrs_work_type front_work, back_work;

   tcrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .height    (req_tdata[15:0]),
      .normal_x  (req_tdata[31:16]),
      .normal_y  (req_tdata[47:32]),
      .normal_z  (req_tdata[63:48]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_work  (front_work)
   );

   tcrs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_work  (front_work),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_work  (back_work)
   );

   tcrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (back_valid),
      .in_ready   (back_ready),
      .in_work    (back_work),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .pixel_abgr (rsp_tdata)
   );

endmodule
